// ----- design/rbs_pkg.sv -----
// ----------------------------------------------------------------------------
// rbs_pkg: shared types and constants of the running bout segmenter
// Field widths, register indexes, queue sizes and the request types that pass
// between the classifier front end and the judging back end.
// ----------------------------------------------------------------------------
package rbs_pkg;

  localparam int SPEED_W = 16;
  localparam int POS_W   = 16;
  localparam int TIME_W  = 32;
  localparam int TAG_W   = 16;
  localparam int LEN_W   = 16;
  localparam int THR_W   = 16;

  localparam int DIFF_W = POS_W + 1;
  localparam int SQ_W   = 2 * POS_W;
  localparam int D2_W   = SQ_W + 1;
  localparam int SCALE_W = 20;
  localparam int LHS_W  = D2_W + SCALE_W;
  localparam int RATE_W = THR_W + TIME_W;
  localparam int RLIM_W = 28;
  localparam int RR_W   = 2 * RLIM_W;

  localparam logic [SCALE_W-1:0] USEC_SQ    = SCALE_W'(1000000);
  localparam logic [RATE_W-1:0]  RATE_LIMIT = RATE_W'(1) << (RLIM_W - 1);

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_VELOCITY = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_MEAN_RATE    = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_DURATION = CFG_ADDR_W'(2);

  localparam int JOBQ_DEPTH = 4;
  localparam int JOBQ_PTR_W = $clog2(JOBQ_DEPTH);
  localparam int JOBQ_CNT_W = JOBQ_PTR_W + 1;

  localparam int OUTQ_DEPTH = 8;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = OUTQ_PTR_W + 1;

  typedef struct packed {
    logic [DIFF_W-1:0] dx;
    logic [DIFF_W-1:0] dy;
    logic [TIME_W-1:0] dur;
    logic [LEN_W-1:0]  len;
    logic              last;
  } job_t;

  typedef struct packed {
    logic v0;
    logic v1;
    job_t j0;
    job_t j1;
  } push_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             running;
    logic             last;
  } res_t;

endpackage

// ----- design/rbs_front.sv -----
// ----------------------------------------------------------------------------
// rbs_front: sample classifier
// Tracks the open segment and turns each accepted sample into zero, one or two
// judging requests, in the order in which the segments close.
// ----------------------------------------------------------------------------
module rbs_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  logic [rbs_pkg::SPEED_W-1:0]       speed,
  input  logic [rbs_pkg::POS_W-1:0]         pos_x,
  input  logic [rbs_pkg::POS_W-1:0]         pos_y,
  input  logic [rbs_pkg::TIME_W-1:0]        time_ms,
  input  logic [rbs_pkg::TAG_W-1:0]         trial_tag,
  input  logic                              end_of_data,
  input  logic [rbs_pkg::SPEED_W-1:0]       min_velocity,
  output rbs_pkg::push_t                    push
);

  logic                         open_r, open_nxt;
  logic [rbs_pkg::POS_W-1:0]    sx_r, sx_nxt, sy_r, sy_nxt, ex_r, ex_nxt, ey_r, ey_nxt;
  logic [rbs_pkg::TIME_W-1:0]   st_r, st_nxt, et_r, et_nxt;
  logic [rbs_pkg::TAG_W-1:0]    trial_r, trial_nxt;
  logic [rbs_pkg::LEN_W-1:0]    cnt_r, cnt_nxt;
  logic                         fast, joins, close_old, lone, flush, has_second, open_run;
  rbs_pkg::job_t                job_old, job_second;

  function automatic rbs_pkg::job_t make_job(
    input logic [rbs_pkg::POS_W-1:0]  sx,
    input logic [rbs_pkg::POS_W-1:0]  sy,
    input logic [rbs_pkg::TIME_W-1:0] st,
    input logic [rbs_pkg::POS_W-1:0]  ex,
    input logic [rbs_pkg::POS_W-1:0]  ey,
    input logic [rbs_pkg::TIME_W-1:0] et,
    input logic [rbs_pkg::LEN_W-1:0]  len,
    input logic                       last
  );
    rbs_pkg::job_t j;
    j.dx   = {ex[rbs_pkg::POS_W-1], ex} - {sx[rbs_pkg::POS_W-1], sx};
    j.dy   = {ey[rbs_pkg::POS_W-1], ey} - {sy[rbs_pkg::POS_W-1], sy};
    j.dur  = (et > st) ? et - st : rbs_pkg::TIME_W'(1);
    j.len  = len;
    j.last = last;
    return j;
  endfunction

  always_comb begin
    fast      = speed >= min_velocity;
    joins     = open_r && fast && (trial_tag == trial_r);
    open_run  = open_r;
    sx_nxt    = sx_r;
    sy_nxt    = sy_r;
    st_nxt    = st_r;
    ex_nxt    = ex_r;
    ey_nxt    = ey_r;
    et_nxt    = et_r;
    trial_nxt = trial_r;
    cnt_nxt   = cnt_r;
    close_old = 1'b0;
    lone      = 1'b0;
    if (joins) begin
      cnt_nxt = (cnt_r == '1) ? cnt_r : cnt_r + rbs_pkg::LEN_W'(1);
      ex_nxt  = pos_x;
      ey_nxt  = pos_y;
      et_nxt  = time_ms;
    end else begin
      close_old = open_r;
      if (fast) begin
        open_run  = 1'b1;
        sx_nxt    = pos_x;
        sy_nxt    = pos_y;
        st_nxt    = time_ms;
        ex_nxt    = pos_x;
        ey_nxt    = pos_y;
        et_nxt    = time_ms;
        trial_nxt = trial_tag;
        cnt_nxt   = rbs_pkg::LEN_W'(1);
      end else begin
        open_run = 1'b0;
        lone     = 1'b1;
      end
    end
    flush      = end_of_data && open_run;
    open_nxt   = open_run && !end_of_data;
    has_second = lone || flush;
    job_old    = make_job(sx_r, sy_r, st_r, ex_r, ey_r, et_r, cnt_r, !has_second);
    if (lone) begin
      job_second = make_job(pos_x, pos_y, time_ms, pos_x, pos_y, time_ms,
                            rbs_pkg::LEN_W'(1), 1'b1);
    end else begin
      job_second = make_job(sx_nxt, sy_nxt, st_nxt, ex_nxt, ey_nxt, et_nxt, cnt_nxt, 1'b1);
    end
    push.v0 = accept && (close_old || has_second);
    push.v1 = accept && close_old && has_second;
    push.j0 = close_old ? job_old : job_second;
    push.j1 = job_second;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
    end else if (accept) begin
      open_r <= open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sx_r    <= sx_nxt;
      sy_r    <= sy_nxt;
      st_r    <= st_nxt;
      ex_r    <= ex_nxt;
      ey_r    <= ey_nxt;
      et_r    <= et_nxt;
      trial_r <= trial_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ----- design/rbs_jobq.sv -----
// ----------------------------------------------------------------------------
// rbs_jobq: request queue between front end and back end
// Takes up to two requests per cycle and hands out one per pop, oldest first.
// ----------------------------------------------------------------------------
module rbs_jobq (
  input  logic           clk,
  input  logic           rst_n,
  input  rbs_pkg::push_t push,
  input  logic           pop,
  output rbs_pkg::job_t  head,
  output logic           empty,
  output logic           full
);

  rbs_pkg::job_t                    mem [rbs_pkg::JOBQ_DEPTH];
  logic [rbs_pkg::JOBQ_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [rbs_pkg::JOBQ_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [rbs_pkg::JOBQ_PTR_W-1:0]   wr_ptr_2nd;
  logic [1:0]                       n_push;

  always_comb begin
    n_push     = 2'(push.v0) + 2'(push.v1);
    wr_ptr_2nd = wr_ptr_r + rbs_pkg::JOBQ_PTR_W'(1);
    wr_ptr_nxt = wr_ptr_r + rbs_pkg::JOBQ_PTR_W'(n_push);
    rd_ptr_nxt = rd_ptr_r + rbs_pkg::JOBQ_PTR_W'(pop);
    cnt_nxt    = cnt_r + rbs_pkg::JOBQ_CNT_W'(n_push) - rbs_pkg::JOBQ_CNT_W'(pop);
    empty      = (cnt_r == '0);
    full       = (cnt_r > rbs_pkg::JOBQ_CNT_W'(rbs_pkg::JOBQ_DEPTH - 2));
    head       = mem[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem[wr_ptr_r] <= push.j0;
    end
    if (push.v1) begin
      mem[wr_ptr_2nd] <= push.j1;
    end
  end

endmodule

// ----- design/rbs_back.sv -----
// ----------------------------------------------------------------------------
// rbs_back: running test pipeline and result queue
// Three registered stages square the displacement, scale it and square the
// threshold times duration; the compare feeds a result queue. Requests are
// taken only while the queue has room for everything in flight.
// ----------------------------------------------------------------------------
module rbs_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rbs_pkg::job_t                job,
  input  logic                         jobq_empty,
  output logic                         job_pop,
  input  logic [rbs_pkg::THR_W-1:0]    mean_rate_threshold,
  input  logic [rbs_pkg::TIME_W-1:0]   min_duration_ms,
  input  logic                         res_pop,
  output rbs_pkg::res_t                res_head,
  output logic                         res_empty
);

  logic                          v1_r, v2_r, v3_r;
  logic [rbs_pkg::SQ_W-1:0]      sqx1_r, sqy1_r;
  logic [rbs_pkg::RATE_W-1:0]    r1_r;
  logic                          dok1_r, dok2_r, dok3_r;
  logic [rbs_pkg::LEN_W-1:0]     len1_r, len2_r, len3_r;
  logic                          last1_r, last2_r, last3_r;
  logic [rbs_pkg::D2_W-1:0]      d2_r;
  logic                          big2_r, big3_r;
  logic [rbs_pkg::RR_W-1:0]      rr2_r, rr3_r;
  logic [rbs_pkg::LHS_W-1:0]     lhs3_r;

  logic signed [2*rbs_pkg::DIFF_W-1:0] px, py;
  logic [rbs_pkg::RATE_W-1:0]          rprod;
  logic [rbs_pkg::RR_W-1:0]            rr;
  logic [rbs_pkg::LHS_W-1:0]           lhs;
  logic [1:0]                          inflight;
  logic [rbs_pkg::OUTQ_CNT_W:0]        credit_use;
  rbs_pkg::res_t                       res_new;

  rbs_pkg::res_t                       mem [rbs_pkg::OUTQ_DEPTH];
  logic [rbs_pkg::OUTQ_PTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [rbs_pkg::OUTQ_CNT_W-1:0]      cnt_r, cnt_nxt;

  always_comb begin
    inflight   = 2'(v1_r) + 2'(v2_r) + 2'(v3_r);
    credit_use = (rbs_pkg::OUTQ_CNT_W+1)'(cnt_r) + (rbs_pkg::OUTQ_CNT_W+1)'(inflight);
    job_pop    = !jobq_empty && (credit_use < (rbs_pkg::OUTQ_CNT_W+1)'(rbs_pkg::OUTQ_DEPTH));
    px         = $signed(job.dx) * $signed(job.dx);
    py         = $signed(job.dy) * $signed(job.dy);
    rprod      = rbs_pkg::RATE_W'(mean_rate_threshold) * rbs_pkg::RATE_W'(job.dur);
    rr         = rbs_pkg::RR_W'(r1_r[rbs_pkg::RLIM_W-1:0])
               * rbs_pkg::RR_W'(r1_r[rbs_pkg::RLIM_W-1:0]);
    lhs        = rbs_pkg::LHS_W'(d2_r) * rbs_pkg::LHS_W'(rbs_pkg::USEC_SQ);
    res_new.len     = len3_r;
    res_new.running = !big3_r && (rbs_pkg::RR_W'(lhs3_r) >= rr3_r) && dok3_r;
    res_new.last    = last3_r;
    cnt_nxt    = cnt_r + rbs_pkg::OUTQ_CNT_W'(v3_r)
               - rbs_pkg::OUTQ_CNT_W'(res_pop && !res_empty);
    res_empty  = (cnt_r == '0);
    res_head   = mem[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      v1_r     <= job_pop;
      v2_r     <= v1_r;
      v3_r     <= v2_r;
      wr_ptr_r <= wr_ptr_r + rbs_pkg::OUTQ_PTR_W'(v3_r);
      rd_ptr_r <= rd_ptr_r + rbs_pkg::OUTQ_PTR_W'(res_pop && !res_empty);
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sqx1_r  <= px[rbs_pkg::SQ_W-1:0];
    sqy1_r  <= py[rbs_pkg::SQ_W-1:0];
    r1_r    <= rprod;
    dok1_r  <= job.dur >= min_duration_ms;
    len1_r  <= job.len;
    last1_r <= job.last;

    d2_r    <= rbs_pkg::D2_W'(sqx1_r) + rbs_pkg::D2_W'(sqy1_r);
    big2_r  <= r1_r > rbs_pkg::RATE_LIMIT;
    rr2_r   <= rr;
    dok2_r  <= dok1_r;
    len2_r  <= len1_r;
    last2_r <= last1_r;

    lhs3_r  <= lhs;
    big3_r  <= big2_r;
    rr3_r   <= rr2_r;
    dok3_r  <= dok2_r;
    len3_r  <= len2_r;
    last3_r <= last2_r;

    if (v3_r) begin
      mem[wr_ptr_r] <= res_new;
    end
  end

endmodule

// ----- design/running_bout_segmenter_top.sv -----
// ----------------------------------------------------------------------------
// running_bout_segmenter_top: running bout segmenter
// Splits a sample stream into segments, one result per closed segment.
// Path: a request waits in the request queue, passes the judging pipeline
// stages, then enters the result queue. Throughput: one sample per cycle
// while in_full is low; two closed segments take the single issue port twice.
// Reset: synchronous, active low; clears the open segment, queues, config
// registers and pipeline valid bits. No clearing pass is needed.
// ----------------------------------------------------------------------------
module running_bout_segmenter_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic [rbs_pkg::SPEED_W-1:0]         in_speed,
  input  logic signed [rbs_pkg::POS_W-1:0]    in_pos_x,
  input  logic signed [rbs_pkg::POS_W-1:0]    in_pos_y,
  input  logic [rbs_pkg::TIME_W-1:0]          in_time_ms,
  input  logic [rbs_pkg::TAG_W-1:0]           in_trial_tag,
  input  logic                                in_end_of_data,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic [rbs_pkg::LEN_W-1:0]           out_segment_length,
  output logic                                out_running,
  output logic                                out_last,
  input  logic                                cfg_we,
  input  logic [rbs_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [rbs_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  logic [rbs_pkg::SPEED_W-1:0] min_velocity_r;
  logic [rbs_pkg::THR_W-1:0]   mean_rate_r;
  logic [rbs_pkg::TIME_W-1:0]  min_duration_r;
  logic                        accept;
  rbs_pkg::push_t              push;
  rbs_pkg::job_t               job_head;
  logic                        jobq_empty, jobq_full, job_pop;
  rbs_pkg::res_t               res_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_velocity_r <= '0;
      mean_rate_r    <= '0;
      min_duration_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        rbs_pkg::REG_MIN_VELOCITY: min_velocity_r <= cfg_wdata[rbs_pkg::SPEED_W-1:0];
        rbs_pkg::REG_MEAN_RATE:    mean_rate_r    <= cfg_wdata[rbs_pkg::THR_W-1:0];
        rbs_pkg::REG_MIN_DURATION: min_duration_r <= cfg_wdata[rbs_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_full = jobq_full;
  assign accept  = in_push && !jobq_full;

  rbs_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .speed        (in_speed),
    .pos_x        (in_pos_x),
    .pos_y        (in_pos_y),
    .time_ms      (in_time_ms),
    .trial_tag    (in_trial_tag),
    .end_of_data  (in_end_of_data),
    .min_velocity (min_velocity_r),
    .push         (push)
  );

  rbs_jobq u_jobq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (job_pop),
    .head  (job_head),
    .empty (jobq_empty),
    .full  (jobq_full)
  );

  rbs_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .job                 (job_head),
    .jobq_empty          (jobq_empty),
    .job_pop             (job_pop),
    .mean_rate_threshold (mean_rate_r),
    .min_duration_ms     (min_duration_r),
    .res_pop             (out_pop),
    .res_head            (res_head),
    .res_empty           (out_empty)
  );

  assign out_segment_length = res_head.len;
  assign out_running        = res_head.running;
  assign out_last           = res_head.last;

endmodule

// ----- design/rbs_checker.sv -----
// ----------------------------------------------------------------------------
// rbs_checker: port level checks of the running bout segmenter
// Watches the top level ports only and is attached to it with a bind.
// ----------------------------------------------------------------------------
module rbs_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_full,
  input logic                                out_empty,
  input logic                                out_pop,
  input logic [rbs_pkg::LEN_W-1:0]           out_segment_length,
  input logic                                out_running,
  input logic                                out_last
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_reset_ready: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input side full after reset");

  a_length_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_segment_length != '0)
    else $error("segment of zero length");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_segment_length)
      && $stable(out_running) && $stable(out_last))
    else $error("waiting result changed");

endmodule

bind running_bout_segmenter_top rbs_checker u_rbs_checker (.*);

// ----- sim/tb_running_bout_segmenter_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_running_bout_segmenter_top: self-checking bench for the bout segmenter
// Feeds sample requests through the input queue and predicts the segment
// results in a local model of the segmenter. Each popped result is compared
// field by field with the oldest prediction. Directed cases come first, then
// random trial runs under several threshold settings, random gaps on both
// sides and a long stall on the result side.
// ----------------------------------------------------------------------------
module tb_running_bout_segmenter_top;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 80;
  localparam logic [rbs_pkg::LEN_W-1:0] LEN_SAT = {rbs_pkg::LEN_W{1'b1}};

  typedef struct {
    logic [rbs_pkg::LEN_W-1:0] len;
    logic                      running;
    logic                      last;
  } seg_result_t;

  logic                              clk;
  logic                              rst_n;
  logic                              in_push;
  logic                              in_full;
  logic [rbs_pkg::SPEED_W-1:0]       in_speed;
  logic signed [rbs_pkg::POS_W-1:0]  in_pos_x;
  logic signed [rbs_pkg::POS_W-1:0]  in_pos_y;
  logic [rbs_pkg::TIME_W-1:0]        in_time_ms;
  logic [rbs_pkg::TAG_W-1:0]         in_trial_tag;
  logic                              in_end_of_data;
  logic                              out_empty;
  logic                              out_pop;
  logic [rbs_pkg::LEN_W-1:0]         out_segment_length;
  logic                              out_running;
  logic                              out_last;
  logic                              cfg_we;
  logic [rbs_pkg::CFG_ADDR_W-1:0]    cfg_addr;
  logic [rbs_pkg::CFG_DATA_W-1:0]    cfg_wdata;

  // Thresholds as the block holds them.
  logic [rbs_pkg::SPEED_W-1:0] min_speed;
  logic [rbs_pkg::THR_W-1:0]   rate_floor;
  logic [rbs_pkg::TIME_W-1:0]  dur_floor;

  // The segment that is still open.
  bit                               seg_open;
  logic signed [rbs_pkg::POS_W-1:0] seg_first_x, seg_first_y, seg_last_x, seg_last_y;
  logic [rbs_pkg::TIME_W-1:0]       seg_first_t, seg_last_t;
  logic [rbs_pkg::TAG_W-1:0]        seg_tag;
  logic [rbs_pkg::LEN_W-1:0]        seg_len;

  seg_result_t pending_segments[$];
  int          mismatch_count;
  int          quiet_cycles;

  bit feed_gaps;
  bit pop_gaps;
  bit hold_results;
  int hold_left;

  logic signed [rbs_pkg::POS_W-1:0] walk_x, walk_y;
  logic [rbs_pkg::TIME_W-1:0]       walk_t;
  logic [rbs_pkg::TAG_W-1:0]        trial_now;

  running_bout_segmenter_top dut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit segment_is_running(input logic signed [rbs_pkg::POS_W-1:0] sx, sy,
                                            input logic [rbs_pkg::TIME_W-1:0] st,
                                            input logic signed [rbs_pkg::POS_W-1:0] ex, ey,
                                            input logic [rbs_pkg::TIME_W-1:0] et);
    longint          dx, dy;
    longint unsigned disp_sq, dur, span;
    bit              rate_ok;
    dx = longint'(ex) - longint'(sx);
    dy = longint'(ey) - longint'(sy);
    disp_sq = dx * dx + dy * dy;
    dur = (et > st) ? et - st : 64'd1;
    span = rate_floor * dur;
    if (span > (64'd1 << 27)) begin
      rate_ok = 1'b0;
    end else begin
      rate_ok = disp_sq * 64'd1000000 >= span * span;
    end
    return rate_ok && dur >= dur_floor;
  endfunction

  function automatic void predict_segments(input logic [rbs_pkg::SPEED_W-1:0] speed,
                                           input logic signed [rbs_pkg::POS_W-1:0] x, y,
                                           input logic [rbs_pkg::TIME_W-1:0] t,
                                           input logic [rbs_pkg::TAG_W-1:0] tag,
                                           input logic eod);
    seg_result_t made[2];
    int          n;
    bit          fast;
    n = 0;
    fast = speed >= min_speed;
    if (seg_open && fast && tag == seg_tag) begin
      if (seg_len != LEN_SAT) seg_len++;
      seg_last_x = x;
      seg_last_y = y;
      seg_last_t = t;
    end else begin
      if (seg_open) begin
        made[n] = '{seg_len, segment_is_running(seg_first_x, seg_first_y, seg_first_t,
                                                seg_last_x, seg_last_y, seg_last_t), 1'b0};
        n++;
        seg_open = 1'b0;
      end
      if (fast) begin
        seg_open = 1'b1;
        seg_first_x = x;
        seg_first_y = y;
        seg_first_t = t;
        seg_last_x = x;
        seg_last_y = y;
        seg_last_t = t;
        seg_tag = tag;
        seg_len = rbs_pkg::LEN_W'(1);
      end else begin
        made[n] = '{rbs_pkg::LEN_W'(1), segment_is_running(x, y, t, x, y, t), 1'b0};
        n++;
      end
    end
    if (eod && seg_open) begin
      made[n] = '{seg_len, segment_is_running(seg_first_x, seg_first_y, seg_first_t,
                                              seg_last_x, seg_last_y, seg_last_t), 1'b0};
      n++;
      seg_open = 1'b0;
    end
    for (int i = 0; i < n; i++) begin
      made[i].last = (i == n - 1);
      pending_segments.push_back(made[i]);
    end
  endfunction

  task automatic send_sample(input logic [rbs_pkg::SPEED_W-1:0] speed,
                             input logic signed [rbs_pkg::POS_W-1:0] x, y,
                             input logic [rbs_pkg::TIME_W-1:0] t,
                             input logic [rbs_pkg::TAG_W-1:0] tag,
                             input logic eod);
    int gap;
    if (feed_gaps && $urandom_range(99) < 20) begin
      in_push <= 1'b0;
      gap = $urandom_range(3, 1);
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_speed <= speed;
    in_pos_x <= x;
    in_pos_y <= y;
    in_time_ms <= t;
    in_trial_tag <= tag;
    in_end_of_data <= eod;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_segments(speed, x, y, t, tag, eod);
  endtask

  task automatic send_walk(input bit fast, input bit eod);
    logic [rbs_pkg::SPEED_W-1:0] speed;
    if (fast || min_speed == 0) begin
      speed = rbs_pkg::SPEED_W'($urandom_range(65535, min_speed));
    end else begin
      speed = rbs_pkg::SPEED_W'($urandom_range(min_speed - 1, 0));
    end
    if ($urandom_range(9) == 0) begin
      walk_x = rbs_pkg::POS_W'($urandom);
      walk_y = rbs_pkg::POS_W'($urandom);
    end else begin
      walk_x = rbs_pkg::POS_W'(int'(walk_x) + $urandom_range(400) - 200);
      walk_y = rbs_pkg::POS_W'(int'(walk_y) + $urandom_range(400) - 200);
    end
    case ($urandom_range(19))
      0: walk_t = $urandom;
      1: walk_t = walk_t - $urandom_range(100);
      default: walk_t = walk_t + $urandom_range(40);
    endcase
    send_sample(speed, walk_x, walk_y, walk_t, trial_now, eod);
  endtask

  // Waits for every predicted result, then for the pipeline to go quiet.
  task automatic settle_block();
    in_push <= 1'b0;
    while (pending_segments.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rbs_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [rbs_pkg::CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic configure(input logic [rbs_pkg::SPEED_W-1:0] vel,
                           input logic [rbs_pkg::THR_W-1:0] thr,
                           input logic [rbs_pkg::TIME_W-1:0] dur_ms);
    write_reg(rbs_pkg::REG_MIN_VELOCITY, {16'($urandom), vel});
    write_reg(rbs_pkg::REG_MEAN_RATE, {16'($urandom), thr});
    write_reg(rbs_pkg::REG_MIN_DURATION, dur_ms);
    cfg_we <= 1'b0;
    min_speed = vel;
    rate_floor = thr;
    dur_floor = dur_ms;
  endtask

  task automatic random_thresholds();
    logic [rbs_pkg::SPEED_W-1:0] vel;
    logic [rbs_pkg::THR_W-1:0]   thr;
    logic [rbs_pkg::TIME_W-1:0]  dur_ms;
    int                          pick;
    pick = $urandom_range(19);
    vel = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
          (pick < 5) ? 16'($urandom) : 16'($urandom_range(3000, 500));
    pick = $urandom_range(19);
    thr = (pick < 2) ? 16'd0 : (pick == 2) ? 16'hFFFF :
          (pick < 5) ? 16'($urandom) : 16'($urandom_range(8000));
    pick = $urandom_range(19);
    dur_ms = (pick < 3) ? 32'd0 : (pick == 3) ? 32'hFFFF_FFFF :
             (pick == 4) ? 32'($urandom) : 32'($urandom_range(300));
    settle_block();
    configure(vel, thr, dur_ms);
  endtask

  // Mostly runs of one trial above the speed floor, mixed with noise and lone samples.
  task automatic run_random_bouts(input int item_goal);
    int sent;
    int run_len;
    int kind;
    sent = 0;
    while (sent < item_goal) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        if ($urandom_range(2) != 0) begin
          trial_now = ($urandom_range(3) == 0) ? rbs_pkg::TAG_W'($urandom)
                                               : trial_now + 1'b1;
        end
        run_len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        for (int i = 0; i < run_len; i++) begin
          send_walk(1'b1, i == run_len - 1 && $urandom_range(7) == 0);
        end
        sent += run_len;
        if ($urandom_range(1) == 0) begin
          send_walk(1'b0, $urandom_range(9) == 0);
          sent++;
        end
      end else if (kind < 90) begin
        send_sample(rbs_pkg::SPEED_W'($urandom), rbs_pkg::POS_W'($urandom),
                    rbs_pkg::POS_W'($urandom),
                    ($urandom_range(1) == 0) ? rbs_pkg::TIME_W'($urandom)
                                             : walk_t + $urandom_range(20),
                    ($urandom_range(1) == 0) ? trial_now : rbs_pkg::TAG_W'($urandom),
                    $urandom_range(9) == 0);
        sent++;
      end else begin
        send_walk(1'b0, $urandom_range(5) == 0);
        sent++;
      end
    end
  endtask

  task automatic test_reset_state();
    send_sample(16'd0, 16'sd0, 16'sd0, 32'd0, 16'd0, 1'b0);
    send_sample(16'd0, 16'sd100, -16'sd100, 32'd10, 16'd0, 1'b0);
    send_sample(16'hFFFF, 16'sd5, 16'sd5, 32'd20, 16'd1, 1'b1);
  endtask

  task automatic test_segment_cases();
    settle_block();
    configure(16'd1000, 16'd100, 32'd50);
    send_sample(16'd999, -16'sd32768, 16'sd32767, 32'd0, 16'd7, 1'b0);
    send_sample(16'd1000, -16'sd32768, -16'sd32768, 32'd100, 16'd7, 1'b0);
    send_sample(16'hFFFF, 16'sd32767, 16'sd32767, 32'd200, 16'd7, 1'b0);
    send_sample(16'd5000, 16'sd0, 16'sd0, 32'd300, 16'd8, 1'b0);
    send_sample(16'd2000, 16'sd10, 16'sd0, 32'd250, 16'd8, 1'b0);
    send_sample(16'd0, 16'sd0, 16'sd0, 32'd400, 16'd8, 1'b1);
    send_sample(16'd12, 16'sd1, 16'sd1, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    send_sample(16'hFFFF, 16'sd2, 16'sd2, 32'd500, 16'hFFFF, 1'b1);
    send_sample(16'd3000, 16'sd0, 16'sd0, 32'd1000, 16'd9, 1'b0);
    send_sample(16'd3000, 16'sd1000, 16'sd0, 32'd1060, 16'd9, 1'b1);
    send_sample(16'd3000, 16'sd0, 16'sd0, 32'd2000, 16'd10, 1'b0);
    send_sample(16'd3000, 16'sd50, 16'sd50, 32'd2100, 16'd11, 1'b1);
  endtask

  task automatic test_threshold_extremes();
    settle_block();
    configure(16'd1, 16'd0, 32'd1);
    send_sample(16'd0, 16'sd7, -16'sd7, 32'd5, 16'd2, 1'b0);
    settle_block();
    configure(16'd1, 16'd0, 32'd2);
    send_sample(16'd0, 16'sd7, -16'sd7, 32'd5, 16'd2, 1'b0);
    settle_block();
    configure(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_sample(16'hFFFE, 16'sd0, 16'sd0, 32'd0, 16'd3, 1'b0);
    send_sample(16'hFFFF, -16'sd32768, -16'sd32768, 32'd0, 16'd3, 1'b0);
    send_sample(16'hFFFF, 16'sd32767, 16'sd32767, 32'hFFFF_FFFF, 16'd3, 1'b1);
  endtask

  // Threshold changes land while a run is open; the run is judged on closing.
  task automatic test_config_mid_run();
    settle_block();
    configure(16'd100, 16'd0, 32'd0);
    send_sample(16'd150, 16'sd0, 16'sd0, 32'd0, 16'd20, 1'b0);
    settle_block();
    configure(16'd100, 16'd1000, 32'd5);
    send_sample(16'd150, 16'sd3, 16'sd4, 32'd5, 16'd20, 1'b1);
    send_sample(16'd300, 16'sd0, 16'sd0, 32'd0, 16'd21, 1'b0);
    send_sample(16'd300, 16'sd3, 16'sd4, 32'd5, 16'd21, 1'b0);
    settle_block();
    configure(16'd200, 16'd1001, 32'd5);
    send_sample(16'd150, 16'sd9, 16'sd9, 32'd9, 16'd21, 1'b0);
  endtask

  task automatic test_random_bouts();
    for (int phase = 0; phase < 6; phase++) begin
      random_thresholds();
      run_random_bouts(100);
    end
  endtask

  task automatic test_no_idle();
    random_thresholds();
    feed_gaps = 1'b0;
    pop_gaps = 1'b0;
    run_random_bouts(100);
    feed_gaps = 1'b1;
    pop_gaps = 1'b1;
  endtask

  task automatic test_backpressure();
    settle_block();
    configure(16'd1000, 16'($urandom_range(3000)), 32'($urandom_range(100)));
    feed_gaps = 1'b0;
    hold_results = 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_walk(i % 3 == 0, 1'b0);
    end
    feed_gaps = 1'b1;
  endtask

  initial begin
    out_pop <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        hold_left = HOLD_CYCLES;
        hold_results = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (pop_gaps && $urandom_range(99) < 20) begin
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    seg_result_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_segments.size() == 0) begin
        $display("%0t: unexpected result length=%0d running=%0b last=%0b", $time,
                 out_segment_length, out_running, out_last);
        mismatch_count++;
      end else begin
        want = pending_segments.pop_front();
        if (out_segment_length !== want.len) begin
          $display("%0t: segment_length expected %0d, got %0d", $time, want.len,
                   out_segment_length);
          mismatch_count++;
        end
        if (out_running !== want.running) begin
          $display("%0t: running expected %0b, got %0b", $time, want.running, out_running);
          mismatch_count++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last expected %0b, got %0b", $time, want.last, out_last);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no request accepted for %0d cycles", $time, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_push <= 1'b0;
    in_speed <= '0;
    in_pos_x <= '0;
    in_pos_y <= '0;
    in_time_ms <= '0;
    in_trial_tag <= '0;
    in_end_of_data <= 1'b0;
    cfg_we <= 1'b0;
    cfg_addr <= rbs_pkg::REG_MIN_VELOCITY;
    cfg_wdata <= '0;
    min_speed = '0;
    rate_floor = '0;
    dur_floor = '0;
    seg_open = 1'b0;
    seg_first_x = '0;
    seg_first_y = '0;
    seg_first_t = '0;
    seg_last_x = '0;
    seg_last_y = '0;
    seg_last_t = '0;
    seg_tag = '0;
    seg_len = '0;
    mismatch_count = 0;
    quiet_cycles = 0;
    feed_gaps = 1'b1;
    pop_gaps = 1'b1;
    hold_results = 1'b0;
    walk_x = '0;
    walk_y = '0;
    walk_t = $urandom;
    trial_now = rbs_pkg::TAG_W'($urandom);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_segment_cases();
    test_threshold_extremes();
    test_config_mid_run();
    test_random_bouts();
    test_no_idle();
    test_backpressure();
    settle_block();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
